/* design/sek_pkg.sv */
// Shared package of the squared-exponential kernel core.
// Holds widths, register indexes, the sequencer state type and the exp step table.
// No dependencies.
`timescale 1ns / 1ps

package sek_pkg;

    localparam int MAX_DIMS    = 6;
    localparam int COORD_WIDTH = 16;

    localparam int DIM_W     = 3;
    localparam int WEIGHT_W  = 16;
    localparam int SUM_W     = 32;
    localparam int OUT_W     = 16;
    localparam int MAG_W     = 33;
    localparam int SQ_W      = 16;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 33;
    localparam int LOG_W     = 8;
    localparam int EXP_STEPS = 12;
    localparam int K_W       = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [SUM_W-1:0]  EXP_LIMIT   = SUM_W'(12 << 16);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(4096);
    localparam logic [DIM_W-1:0]  NUM_DIMS_RST = DIM_W'(1);
    localparam logic [K_W-1:0]    K_LAST       = K_W'(EXP_STEPS - 1);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LAST = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_WT,
        S_ACC,
        S_EXP_L2,
        S_EXP_L3,
        S_EXP_SEED,
        S_EXP_MUL,
        S_EXP_RND,
        S_EXP_OUT
    } t_state;

    typedef struct packed {
        logic [DIM_W-1:0]    count;
        logic [WEIGHT_W-1:0] weight;
    } t_cfg_rd;

    // exp(-2^(k-8)) in Q0.32
    function automatic logic [MUL_W-1:0] exp_step_const(input logic [K_W-1:0] k);
        logic [MUL_W-1:0] c;
        unique case (k)
            4'd0:    c = 32'd4278222805;
            4'd1:    c = 32'd4261543595;
            4'd2:    c = 32'd4228380000;
            4'd3:    c = 32'd4162825044;
            4'd4:    c = 32'd4034748382;
            4'd5:    c = 32'd3790295335;
            4'd6:    c = 32'd3344923893;
            4'd7:    c = 32'd2605029347;
            4'd8:    c = 32'd1580030169;
            4'd9:    c = 32'd581260615;
            4'd10:   c = 32'd78665070;
            4'd11:   c = 32'd1441160;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

/* design/sek_mul.sv */
// Shared 32x32 unsigned multiplier with registered product.
// Depends on sek_pkg for operand widths.
`timescale 1ns / 1ps

module sek_mul (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [sek_pkg::MUL_W-1:0]  i_a,
    input  logic [sek_pkg::MUL_W-1:0]  i_b,
    output logic [sek_pkg::PROD_W-1:0] o_p
);
    import sek_pkg::*;

    logic [PROD_W-1:0] r_p;
    logic [PROD_W-1:0] n_p;

    assign n_p = PROD_W'(i_a) * PROD_W'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

/* design/sek_cfg.sv */
// Configuration register file: dimension count and per-dimension weights.
// Depends on sek_pkg; returns the clamped count and the current dimension's weight.
`timescale 1ns / 1ps

module sek_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [sek_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [sek_pkg::CFG_DAT_W-1:0] i_wr_data,
    input  logic [sek_pkg::DIM_W-1:0]     i_dim,
    output sek_pkg::t_cfg_rd             o_rd
);
    import sek_pkg::*;

    logic [DIM_W-1:0]    r_num_dims;
    logic [WEIGHT_W-1:0] r_weight [MAX_DIMS];
    logic [DIM_W-1:0]    wr_slot;
    logic [DIM_W-1:0]    rd_slot;

    assign wr_slot = i_wr_index - CFG_WEIGHT_0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= NUM_DIMS_RST;
            for (int i = 0; i < MAX_DIMS; i++) begin
                r_weight[i] <= WEIGHT_RST;
            end
        end else if (i_wr_en) begin
            if (i_wr_index == CFG_NUM_DIMS) begin
                r_num_dims <= i_wr_data[DIM_W-1:0];
            end else if (i_wr_index <= CFG_WEIGHT_LAST) begin
                r_weight[wr_slot] <= i_wr_data[WEIGHT_W-1:0];
            end
        end
    end

    // Clamp the count to 1..MAX_DIMS and the slot to the last weight
    always_comb begin
        rd_slot = (i_dim < DIM_W'(MAX_DIMS)) ? i_dim : DIM_W'(MAX_DIMS - 1);
        if (r_num_dims == '0) begin
            o_rd.count = DIM_W'(1);
        end else if (r_num_dims > DIM_W'(MAX_DIMS)) begin
            o_rd.count = DIM_W'(MAX_DIMS);
        end else begin
            o_rd.count = r_num_dims;
        end
        o_rd.weight = r_weight[rd_slot];
    end

endmodule

/* design/squared_exponential_kernel_core.sv */
// Weighted squared-exponential kernel core: top level with sequencer and datapath.
// Flow: an item is accepted only in the idle state, so a new item is taken only once the last
// has been squared, weighted and added; the item that ends a pair then runs the exp steps
// (skipped when the sum is 12.0 or more) and waits for the result register to empty.
// All products come from the one shared 32x32 multiplier. Reset: synchronous, active low;
// clears the state, sum, dimension and step counters, result valid and configuration registers.
`timescale 1ns / 1ps

module squared_exponential_kernel_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [sek_pkg::COORD_WIDTH-1:0] i_first_coord,
    input  logic [sek_pkg::COORD_WIDTH-1:0] i_second_coord,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [sek_pkg::OUT_W-1:0]       o_kernel_value,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sek_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sek_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import sek_pkg::*;

    // Sequencer state
    t_state r_state;
    t_state n_state;

    // Item and pair state
    logic [SQ_W-1:0]  r_mag;       // |first - second|, low bits
    logic             r_big;       // difference does not fit 16 bits
    logic [SUM_W-1:0] r_sum;       // Q16.16 distance sum
    logic [DIM_W-1:0] r_dim;       // dimension of the next item
    logic             r_zero;      // sum at or above 12.0: result is 0

    // exp evaluation
    logic [SQ_W-1:0]  r_l2;        // l*l of the low fraction byte
    logic [ACC_W-1:0] r_acc;       // Q0.32 running value, may equal 1.0
    logic [K_W-1:0]   r_k;         // exponent bit under test

    // Result register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    // Combinational helpers
    logic             in_accept;
    logic             slot_free;
    logic             mul_en;
    logic [MUL_W-1:0] mul_a;
    logic [MUL_W-1:0] mul_b;
    logic [PROD_W-1:0] prod;
    t_cfg_rd          cfg_rd;
    logic [MAG_W-1:0] first_ext;
    logic [MAG_W-1:0] second_ext;
    logic [MAG_W-1:0] diff;
    logic [MAG_W-1:0] mag;
    logic [36:0]      term_raw;
    logic [SUM_W-1:0] term;
    logic [SUM_W:0]   sum_raw;
    logic [SUM_W-1:0] sum_new;
    logic             last_dim;
    logic [LOG_W-1:0] lfrac;
    logic [6:0]       cube_hi;
    logic [12:0]      third_raw;
    logic [ACC_W:0]   seed;
    logic             exp_bit;
    logic [ACC_W-1:0] rnd_raw;
    logic [ACC_W:0]   res_raw;
    logic [OUT_W-1:0] res;

    assign in_accept = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Shared multiplier and configuration registers
    // ------------------------------------------------------------------
    sek_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    sek_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .i_dim      (r_dim),
        .o_rd       (cfg_rd)
    );

    // ------------------------------------------------------------------
    // Datapath arithmetic
    // ------------------------------------------------------------------
    always_comb begin
        // Difference of the coordinates, exact, and its magnitude
        first_ext  = {{(MAG_W - COORD_WIDTH){i_first_coord[COORD_WIDTH-1]}}, i_first_coord};
        second_ext = {{(MAG_W - COORD_WIDTH){i_second_coord[COORD_WIDTH-1]}}, i_second_coord};
        diff       = first_ext - second_ext;
        mag        = diff[MAG_W-1] ? (MAG_W'(0) - diff) : diff;

        // Weighted term: round half up from Q20.28 to Q16.16, saturate
        term_raw = 37'((49'(prod[47:0]) + 49'd2048) >> 12);
        if (r_big) begin
            term = (cfg_rd.weight != '0) ? '1 : '0;
        end else if (|term_raw[36:SUM_W]) begin
            term = '1;
        end else begin
            term = term_raw[SUM_W-1:0];
        end

        // Saturating accumulate
        sum_raw = {1'b0, r_sum} + {1'b0, term};
        sum_new = sum_raw[SUM_W] ? '1 : sum_raw[SUM_W-1:0];
        last_dim = ({1'b0, r_dim} + 4'd1) >= {1'b0, cfg_rd.count};

        // Seed of exp: 1 - l + l^2/2 - l^3/6 over the low fraction byte;
        // l^3 / 393216 is (l^3 >> 17) / 3, the divide by 3 as *43 >> 7
        lfrac     = r_sum[LOG_W-1:0];
        cube_hi   = prod[23:17];
        third_raw = 13'(cube_hi) * 13'd43;
        seed      = (34'd1 << 32) - {10'd0, lfrac, 16'd0}
                    + 34'(r_l2 >> 1) - 34'(third_raw[12:7]);

        // Exponent bit of weight 2^(k-8) and the rounded Q0.32 product
        exp_bit = r_sum[LOG_W + 32'(r_k)];
        rnd_raw = ACC_W'({1'b0, prod[PROD_W-1:31]} + 34'd1);

        // Final rounding to Q0.16 with saturation and underflow to zero
        res_raw = {1'b0, r_acc} + 34'h8000;
        if (r_zero || (r_acc < ACC_W'(32'h10000))) begin
            res = '0;
        end else if (|res_raw[ACC_W:OUT_W + 16]) begin
            res = '1;
        end else begin
            res = res_raw[OUT_W + 15:16];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = S_SQ;
            end
            S_SQ:       n_state = S_WT;
            S_WT:       n_state = S_ACC;
            S_ACC: begin
                if (!last_dim) begin
                    n_state = S_IDLE;
                end else if (sum_new >= EXP_LIMIT) begin
                    n_state = S_EXP_OUT;
                end else begin
                    n_state = S_EXP_L2;
                end
            end
            S_EXP_L2:   n_state = S_EXP_L3;
            S_EXP_L3:   n_state = S_EXP_SEED;
            S_EXP_SEED: n_state = S_EXP_MUL;
            S_EXP_MUL: begin
                if (exp_bit) begin
                    n_state = S_EXP_RND;
                end else if (r_k == K_LAST) begin
                    n_state = S_EXP_OUT;
                end else begin
                    n_state = S_EXP_MUL;
                end
            end
            S_EXP_RND:  n_state = (r_k == K_LAST) ? S_EXP_OUT : S_EXP_MUL;
            S_EXP_OUT: begin
                if (slot_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs and multiplier operand selection
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready = 1'b0;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_SQ: begin
                // square the magnitude
                mul_en = 1'b1;
                mul_a  = MUL_W'(r_mag);
                mul_b  = MUL_W'(r_mag);
            end
            S_WT: begin
                // weight the square
                mul_en = 1'b1;
                mul_a  = prod[MUL_W-1:0];
                mul_b  = MUL_W'(cfg_rd.weight);
            end
            S_EXP_L2: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(lfrac);
                mul_b  = MUL_W'(lfrac);
            end
            S_EXP_L3: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(prod[SQ_W-1:0]);
                mul_b  = MUL_W'(lfrac);
            end
            S_EXP_MUL: begin
                mul_en = exp_bit;
                mul_a  = r_acc[MUL_W-1:0];
                mul_b  = exp_step_const(r_k);
            end
            S_ACC, S_EXP_SEED, S_EXP_RND, S_EXP_OUT: begin
                mul_en = 1'b0;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pair state and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_dim       <= '0;
            r_zero      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // raise the result once the register is free, drop it once taken
            if ((r_state == S_EXP_OUT) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_ACC: begin
                    r_sum <= sum_new;
                    if (last_dim) begin
                        r_dim  <= '0;
                        r_zero <= (sum_new >= EXP_LIMIT);
                    end else begin
                        r_dim  <= r_dim + DIM_W'(1);
                    end
                end
                S_EXP_SEED: begin
                    r_k <= '0;
                end
                S_EXP_MUL: begin
                    // advance past a clear exponent bit
                    if (!exp_bit) r_k <= r_k + K_W'(1);
                end
                S_EXP_RND: begin
                    r_k <= r_k + K_W'(1);
                end
                S_EXP_OUT: begin
                    // hold until the result register is free, then clear the pair
                    if (slot_free) begin
                        r_sum       <= '0;
                        r_zero      <= 1'b0;
                    end
                end
                S_IDLE, S_SQ, S_WT, S_EXP_L2, S_EXP_L3: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mag <= mag[SQ_W-1:0];
            r_big <= |mag[MAG_W-1:SQ_W];
        end
        if (r_state == S_EXP_L3) begin
            r_l2 <= prod[SQ_W-1:0];
        end
        if (r_state == S_EXP_SEED) begin
            r_acc <= seed[ACC_W-1:0];
        end
        if (r_state == S_EXP_RND) begin
            // exactly 1.0 times c is c itself
            r_acc <= r_acc[ACC_W-1] ? ACC_W'(exp_step_const(r_k)) : {1'b0, rnd_raw[ACC_W-1:1]};
        end
        if ((r_state == S_EXP_OUT) && slot_free) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kernel_value = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_dim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dim < DIM_W'(MAX_DIMS))
        else $error("dimension counter past the last weight");

    a_out_from_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EXP_OUT))
        else $error("result raised outside the output step");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_SQ))
        else $error("accepted item did not start squaring");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP_MUL || r_state == S_EXP_RND) |-> (r_k <= K_LAST))
        else $error("exp step counter overran");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench of the squared-exponential kernel core.
// Drives coordinate items and register writes, predicts every kernel value; needs sek_pkg.
`timescale 1ns / 1ps

module testbench;
    import sek_pkg::*;

    // exp(-2^(k-8)) in Q0.32, one entry per bit of the sum from 2^-8 up to 2^3
    localparam logic [31:0] NEG_EXP_STEP [12] = '{
        32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260615,  32'd78665070,   32'd1441160
    };
    localparam logic [31:0] SUM_CUTOFF = 32'h000C_0000;   // 12.0 in Q16.16
    localparam logic [15:0] CORNER [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS = 500;

    // Tracks the kernel state alongside the block and holds the kernel values still owed.
    class kernel_scoreboard;
        logic [DIM_W-1:0]    num_dims;
        logic [WEIGHT_W-1:0] weights [MAX_DIMS];
        logic [SUM_W-1:0]    distance_sum;
        int unsigned         dim_idx;
        logic [OUT_W-1:0]    expected_kernels [$];
        int                  fails;

        function new();
            num_dims = NUM_DIMS_RST;
            foreach (weights[i]) weights[i] = WEIGHT_RST;
            distance_sum = '0;
            dim_idx = 0;
            fails = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == CFG_NUM_DIMS)
                num_dims = data[DIM_W-1:0];
            else if (idx >= CFG_WEIGHT_0 && idx <= CFG_WEIGHT_LAST)
                weights[idx - CFG_WEIGHT_0] = data;
        endfunction

        // exp(-x) for a Q16.16 sum, as Q0.16
        function logic [OUT_W-1:0] neg_exp_q16(logic [SUM_W-1:0] x);
            longint unsigned l, acc, r;
            if (x >= SUM_CUTOFF)
                return '0;
            l = x[7:0];
            acc = (64'd1 << 32) - (l << 16) + ((l * l) >> 1) - (l * l * l) / 393216;
            for (int k = 0; k < 12; k++) begin
                if (x[8 + k])
                    acc = (acc * NEG_EXP_STEP[k] + 64'h8000_0000) >> 32;
            end
            if (acc < 64'h1_0000)
                return '0;
            r = (acc + 64'h8000) >> 16;
            if (r > 64'hFFFF)
                r = 64'hFFFF;
            return r[OUT_W-1:0];
        endfunction

        function void note_item(logic [COORD_WIDTH-1:0] a, logic [COORD_WIDTH-1:0] b);
            longint          diff;
            longint unsigned mag, term, total;
            int unsigned     cnt;
            logic [WEIGHT_W-1:0] w;
            cnt = num_dims;
            if (cnt < 1)
                cnt = 1;
            if (cnt > MAX_DIMS)
                cnt = MAX_DIMS;
            w = weights[dim_idx < MAX_DIMS ? dim_idx : MAX_DIMS - 1];
            diff = longint'($signed(a)) - longint'($signed(b));
            mag = (diff < 0) ? -diff : diff;
            if (mag > 64'hFFFF) begin
                term = (w != 0) ? 64'hFFFF_FFFF : 64'd0;
            end else begin
                term = (mag * mag * w + 64'd2048) >> 12;
                if (term > 64'hFFFF_FFFF)
                    term = 64'hFFFF_FFFF;
            end
            total = distance_sum + term;
            if (total > 64'hFFFF_FFFF)
                total = 64'hFFFF_FFFF;
            distance_sum = total[SUM_W-1:0];
            // the last dimension of the pair, or a count lowered below the current one
            if (dim_idx + 1 >= cnt) begin
                expected_kernels.push_back(neg_exp_q16(distance_sum));
                distance_sum = '0;
                dim_idx = 0;
            end else begin
                dim_idx = (dim_idx + 1) & 7;
            end
        endfunction

        function void flag(string what, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
            fails++;
            if (fails <= 10)
                $display("%0t: kernel_value %s: expected %0d, got %0d", $realtime, what,
                         want, got);
        endfunction

        function void check_result(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (expected_kernels.size() == 0) begin
                flag("with none outstanding", 'x, got);
            end else begin
                want = expected_kernels.pop_front();
                if (got !== want)
                    flag("mismatch", want, got);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [COORD_WIDTH-1:0] i_first_coord = '0;
    logic [COORD_WIDTH-1:0] i_second_coord = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [OUT_W-1:0]       o_kernel_value;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]   i_cfg_data = '0;

    kernel_scoreboard       sb;
    logic [WEIGHT_W-1:0]    weight_plan [MAX_DIMS];
    bit                     steady = 1'b0;   // suppress idling on both sides

    squared_exponential_kernel_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: stall about a quarter of the cycles unless in the steady stretch
    always @(posedge i_clk)
        i_out_ready <= steady || ($urandom_range(0, 99) >= 26);

    // Compare every accepted kernel value with the oldest one owed
    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_kernel_value);

    // Offer one coordinate pair and hold it until accepted. Valid is left high on return,
    // so back-to-back items keep it up; settle lowers it, and so may the next call.
    task automatic send_item(input logic [COORD_WIDTH-1:0] a, input logic [COORD_WIDTH-1:0] b);
        if (!steady) begin
            while ($urandom_range(0, 99) < 26) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_first_coord  <= a;
        i_second_coord <= b;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_item(a, b);
    endtask

    // Drop valid, drain every owed kernel value, then let an unfinished item run out
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.expected_kernels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the dimension count and all six weights; the block must be idle
    task automatic apply_setting(input logic [DIM_W-1:0] dims);
        for (int r = 0; r <= MAX_DIMS; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (r == 0) ? CFG_NUM_DIMS : CFG_IDX_W'(CFG_WEIGHT_0 + r - 1);
            i_cfg_data  <= (r == 0) ? CFG_DAT_W'(dims) : weight_plan[r - 1];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            sb.write_reg((r == 0) ? CFG_NUM_DIMS : CFG_IDX_W'(CFG_WEIGHT_0 + r - 1),
                         (r == 0) ? CFG_DAT_W'(dims) : weight_plan[r - 1]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int                     random_items;
        int                     burst;
        int                     span;
        logic [COORD_WIDTH-1:0] a, b;
        logic [DIM_W-1:0]       dims;

        sb = new();
        random_items = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: one dimension, unit weight
        send_item(16'h0000, 16'h0000);      // zero distance, saturates to full scale
        send_item(16'h7FFF, 16'h8000);      // widest difference, sum far above 12.0
        send_item(16'h8000, 16'h7FFF);
        send_item(16'h0100, 16'h0000);      // exp(-1)
        send_item(16'h0000, 16'h0001);      // smallest non-zero difference
        send_item(16'h0376, 16'h0000);      // sum just under 12.0
        send_item(16'h0377, 16'h0000);      // sum just over 12.0, gives zero
        settle();

        // Three dimensions, weights at the extremes
        weight_plan = '{16'd0, 16'hFFFF, 16'd1, 16'd4096, 16'd8192, 16'd2048};
        apply_setting(3'd3);
        send_item(16'h1234, 16'h1334);
        send_item(16'h0010, 16'h0000);
        send_item(16'h0000, 16'h0040);
        settle();

        // Zero count acts as one dimension
        apply_setting(3'd0);
        send_item(16'h0080, 16'h0000);
        settle();

        // Count above the maximum acts as the maximum
        apply_setting(3'd7);
        for (int j = 0; j < MAX_DIMS; j++)
            send_item(COORD_WIDTH'(j * 37), COORD_WIDTH'(-j * 11));
        settle();

        // Lower the count mid pair: the next item ends the pair at once
        apply_setting(3'd4);
        for (int j = 0; j < 3; j++)
            send_item(COORD_WIDTH'(j * 23), COORD_WIDTH'(j * 5));
        settle();
        apply_setting(3'd2);
        send_item(16'h0020, 16'hFFE0);
        settle();

        // Random phases: a fresh setting, then a burst of coordinate pairs
        while (random_items < RANDOM_ITEMS) begin
            settle();
            case ($urandom_range(0, 9))
                0:       dims = 3'd0;
                1:       dims = 3'd7;
                default: dims = DIM_W'($urandom_range(1, MAX_DIMS));
            endcase
            foreach (weight_plan[i]) begin
                case ($urandom_range(0, 7))
                    0:       weight_plan[i] = 16'd0;
                    1:       weight_plan[i] = 16'hFFFF;
                    2:       weight_plan[i] = 16'd4096;
                    3:       weight_plan[i] = WEIGHT_W'($urandom_range(1, 255));
                    4:       weight_plan[i] = WEIGHT_W'($urandom_range(0, 65535));
                    default: weight_plan[i] = WEIGHT_W'($urandom_range(256, 16384));
                endcase
            end
            apply_setting(dims);
            burst = $urandom_range(6, 40);
            for (int j = 0; j < burst; j++) begin
                // a long stretch with no idling on either side
                steady = (random_items >= 180 && random_items < 280);
                a = COORD_WIDTH'($urandom);
                case ($urandom_range(0, 9))
                    0: b = COORD_WIDTH'($urandom);
                    1: begin
                        a = CORNER[$urandom_range(0, 3)];
                        b = CORNER[$urandom_range(0, 3)];
                    end
                    default: begin
                        // mostly close pairs, so the sum stays below the cutoff
                        case ($urandom_range(0, 2))
                            0:       span = 16;
                            1:       span = 256;
                            default: span = 1024;
                        endcase
                        b = COORD_WIDTH'(int'(a) + $urandom_range(0, 2 * span) - span);
                    end
                endcase
                send_item(a, b);
                random_items++;
            end
        end
        steady = 1'b0;
        settle();

        if (sb.fails == 0 && sb.expected_kernels.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
